[rtl/vfc_pkg.sv]
// shared constants, types and tables for the voxel face cull mesher
`default_nettype none

package vfc_pkg;

    // chunk geometry
    localparam int CHUNK_DIM_X = 16;
    localparam int CHUNK_DIM_Y = 16;
    localparam int CHUNK_DIM_Z = 16;
    localparam int STORE_CELLS = CHUNK_DIM_X * CHUNK_DIM_Y * CHUNK_DIM_Z;
    localparam int ADDR_W      = $clog2(STORE_CELLS);

    typedef logic [ADDR_W-1:0] addr_t;

    // stream widths
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    // block kinds
    localparam logic [3:0] KIND_AIR   = 4'd0;
    localparam logic [3:0] KIND_GRASS = 4'd1;
    localparam logic [3:0] KIND_STONE = 4'd3;

    // texture codes
    localparam logic [1:0] TEX_GRASS_TOP  = 2'd0;
    localparam logic [1:0] TEX_DIRT       = 2'd1;
    localparam logic [1:0] TEX_GRASS_SIDE = 2'd2;
    localparam logic [1:0] TEX_STONE      = 2'd3;

    // face directions
    localparam logic [2:0] FACE_POS_X = 3'd0;
    localparam logic [2:0] FACE_NEG_X = 3'd1;
    localparam logic [2:0] FACE_POS_Y = 3'd2;
    localparam logic [2:0] FACE_NEG_Y = 3'd3;
    localparam logic [2:0] FACE_POS_Z = 3'd4;
    localparam logic [2:0] FACE_NEG_Z = 3'd5;
    localparam int         NUM_FACES  = 6;

    // vertex counter limit within one face
    localparam logic [2:0] VTX_LAST = 3'd5;

    // read select: center cell, then the six neighbors in face order
    localparam logic [2:0] SEL_CENTER = 3'd0;
    localparam logic [2:0] SEL_LAST   = 3'd6;

    // per face and vertex: {dx, dy, dz, u, v}
    localparam logic [4:0] FACE_TAB [6][6] = '{
        '{5'b10000, 5'b11001, 5'b11111, 5'b11111, 5'b10110, 5'b10000},
        '{5'b00100, 5'b01101, 5'b01011, 5'b01011, 5'b00010, 5'b00100},
        '{5'b01100, 5'b11110, 5'b11011, 5'b11011, 5'b01001, 5'b01100},
        '{5'b00001, 5'b10011, 5'b10110, 5'b10110, 5'b00100, 5'b00001},
        '{5'b00100, 5'b10110, 5'b11111, 5'b11111, 5'b01101, 5'b00100},
        '{5'b10010, 5'b00000, 5'b01001, 5'b01001, 5'b11011, 5'b10010}
    };

    // controller to datapath commands
    typedef struct packed {
        logic       latch;
        logic       store_wr;
        logic       rd_en;
        logic [2:0] rd_sel;
        logic       emit_init;
        logic       emit_load;
    } vfc_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic in_mesh;
        logic skip;
        logic out_free;
        logic last_vtx;
    } vfc_stat_t;

    // coordinate inside a chunk dimension
    function automatic logic in_dim(input logic [4:0] c, input int dim);
        return 32'(c) < 32'(dim);
    endfunction

    // linear store address of a cell
    function automatic addr_t cell_addr(input logic [4:0] x, input logic [4:0] y,
                                        input logic [4:0] z);
        return (addr_t'(x) * addr_t'(CHUNK_DIM_Y) + addr_t'(y)) * addr_t'(CHUNK_DIM_Z)
               + addr_t'(z);
    endfunction

    // texture code by block kind and face
    function automatic logic [1:0] tex_for(input logic [3:0] kind, input logic [2:0] dir);
        logic [1:0] t;
        if (kind == KIND_GRASS) begin
            if (dir == FACE_POS_Y) begin
                t = TEX_GRASS_TOP;
            end
            else if (dir == FACE_NEG_Y) begin
                t = TEX_DIRT;
            end
            else begin
                t = TEX_GRASS_SIDE;
            end
        end
        else if (kind == KIND_STONE) begin
            t = TEX_STONE;
        end
        else begin
            t = TEX_DIRT;
        end
        return t;
    endfunction

endpackage

`default_nettype wire

[rtl/voxel_face_cull_mesher.sv]
// top level of the culled-face voxel mesher for one chunk
// Usage:
//   Input items arrive on s_tvalid/s_tready/s_tdata/s_tuser. s_tuser low is a
//   write item: the block kind is stored at the named cell, no output follows.
//   s_tuser high is a mesh item: the named cell and its six neighbors are read
//   and, while m_tready is high, one vertex item per cycle leaves on
//   m_tvalid/m_tready/m_tdata/m_tlast, six per exposed face in the order
//   +X, -X, +Y, -Y, +Z, -Z. m_tlast marks the final vertex of a mesh item.
//   Air, out-of-chunk or fully hidden cells give no output.
// Sequence:
//   a write item is latched at intake and then stored. A mesh item passes
//   intake, seven store reads one a cycle on the single port, a settle step
//   and the face pick before its first vertex, then emits six vertices per
//   exposed face, up to 36 vertices. The next item is taken while the
//   last vertex waits in the output register.
// Reset:
//   clears control state only. Store contents are undefined until written,
//   so every cell read by a mesh item must be written first.
// Stall:
//   while a vertex waits and m_tready is low the walk holds, nothing is dropped.
`default_nettype none

module voxel_face_cull_mesher (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // cell_x[3:0], cell_y[7:4], cell_z[11:8], block_kind[15:12], outside_air[21:16]
    input  logic [vfc_pkg::IN_DATA_W-1:0]      s_tdata,
    // cmd[0]
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // vert_x[4:0], vert_y[9:5], vert_z[14:10], tex_u[15], tex_v[16],
    // texture_sel[18:17], face_dir[21:19]
    output logic [vfc_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                               m_tlast
);

    vfc_pkg::vfc_cmd_t  cmd;
    vfc_pkg::vfc_stat_t stat;

    // sequencer
    vfc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // store and vertex generation
    vfc_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

`default_nettype wire

[rtl/vfc_ctrl.sv]
// controller state machine: item intake, store fetch sequence, vertex emission
`default_nettype none

module vfc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  vfc_pkg::vfc_stat_t  stat,
    output vfc_pkg::vfc_cmd_t   cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_WRITE  = 3'd1;
    localparam logic [2:0] ST_FETCH  = 3'd2;
    localparam logic [2:0] ST_SETTLE = 3'd3;
    localparam logic [2:0] ST_INIT   = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [2:0] fetch_cnt_reg, fetch_cnt_next;

    // state and fetch counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fetch_cnt_reg <= vfc_pkg::SEL_CENTER;
        end
        else
        begin
            state_reg     <= state_next;
            fetch_cnt_reg <= fetch_cnt_next;
        end
    end

    // next state and command decode
    always_comb
    begin
        state_next     = state_reg;
        fetch_cnt_next = fetch_cnt_reg;
        s_tready       = 1'b0;
        cmd            = '0;
        cmd.rd_sel     = fetch_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.latch      = 1'b1;
                    fetch_cnt_next = vfc_pkg::SEL_CENTER;
                    state_next     = stat.in_mesh ? ST_FETCH : ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.store_wr = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_FETCH:
            begin
                cmd.rd_en = 1'b1;
                if (fetch_cnt_reg == vfc_pkg::SEL_LAST)
                begin
                    fetch_cnt_next = vfc_pkg::SEL_CENTER;
                    state_next     = ST_SETTLE;
                end
                else
                begin
                    fetch_cnt_next = fetch_cnt_reg + 3'd1;
                end
            end
            // last neighbor read lands in the air mask here
            ST_SETTLE:
            begin
                state_next = ST_INIT;
            end
            ST_INIT:
            begin
                cmd.emit_init = 1'b1;
                state_next    = stat.skip ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    if (stat.last_vtx)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/vfc_datapath.sv]
// datapath: item registers, block store, air mask, face walk and output register
`default_nettype none

module vfc_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [vfc_pkg::IN_DATA_W-1:0]       s_tdata,
    input  logic                                s_tuser,
    output logic [vfc_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  vfc_pkg::vfc_cmd_t                   cmd,
    output vfc_pkg::vfc_stat_t                  stat
);

    // lowest set bit of a face mask
    function automatic logic [2:0] pick_face(input logic [5:0] m);
        logic [2:0] f;
        f = vfc_pkg::FACE_POS_X;
        for (int i = vfc_pkg::NUM_FACES - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                f = 3'(i);
            end
        end
        return f;
    endfunction

    // faces that come after the given one
    function automatic logic [5:0] faces_after(input logic [2:0] f);
        logic [5:0] m;
        for (int i = 0; i < vfc_pkg::NUM_FACES; i++)
        begin
            m[i] = 3'(i) > f;
        end
        return m;
    endfunction

    // latched item
    logic [3:0] x_reg, y_reg, z_reg, kind_reg;
    logic [5:0] oair_reg;

    // store and read path
    logic [3:0]           store_mem [vfc_pkg::STORE_CELLS];
    logic [3:0]           rd_data_reg;
    logic                 rd_vld_reg;
    logic [2:0]           rd_sel_reg;
    vfc_pkg::addr_t       rd_addr;
    vfc_pkg::addr_t       center_addr;

    // mesh state
    logic [3:0] center_reg;
    logic [5:0] mask_reg;
    logic [2:0] face_reg;
    logic [2:0] vtx_reg;

    // output register
    logic                          out_valid_reg;
    logic                          out_last_reg;
    logic [vfc_pkg::OUT_DATA_W-1:0] out_data_reg;

    logic [4:0] cx, cy, cz;
    logic [4:0] nx, ny, nz;
    logic       center_in;
    logic [5:0] nb_in;
    logic [2:0] cap_face;
    logic [5:0] later_mask;
    logic [4:0] tab_entry;
    logic       last_vtx;

    assign cx = {1'b0, x_reg};
    assign cy = {1'b0, y_reg};
    assign cz = {1'b0, z_reg};

    // chunk bounds of the center and its neighbors
    assign center_in = vfc_pkg::in_dim(cx, vfc_pkg::CHUNK_DIM_X)
                    && vfc_pkg::in_dim(cy, vfc_pkg::CHUNK_DIM_Y)
                    && vfc_pkg::in_dim(cz, vfc_pkg::CHUNK_DIM_Z);
    assign nb_in[vfc_pkg::FACE_POS_X] = vfc_pkg::in_dim(cx + 5'd1, vfc_pkg::CHUNK_DIM_X);
    assign nb_in[vfc_pkg::FACE_NEG_X] = x_reg != 4'd0;
    assign nb_in[vfc_pkg::FACE_POS_Y] = vfc_pkg::in_dim(cy + 5'd1, vfc_pkg::CHUNK_DIM_Y);
    assign nb_in[vfc_pkg::FACE_NEG_Y] = y_reg != 4'd0;
    assign nb_in[vfc_pkg::FACE_POS_Z] = vfc_pkg::in_dim(cz + 5'd1, vfc_pkg::CHUNK_DIM_Z);
    assign nb_in[vfc_pkg::FACE_NEG_Z] = z_reg != 4'd0;

    // neighbor coordinates for the current read select
    always_comb
    begin
        nx = cx;
        ny = cy;
        nz = cz;
        case (cmd.rd_sel)
            3'd1:    nx = cx + 5'd1;
            3'd2:    nx = cx - 5'd1;
            3'd3:    ny = cy + 5'd1;
            3'd4:    ny = cy - 5'd1;
            3'd5:    nz = cz + 5'd1;
            3'd6:    nz = cz - 5'd1;
            default: nx = cx;
        endcase
    end

    assign rd_addr     = vfc_pkg::cell_addr(nx, ny, nz);
    assign center_addr = vfc_pkg::cell_addr(cx, cy, cz);

    // block store, one write or one read a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.store_wr && center_in)
        begin
            store_mem[center_addr] <= kind_reg;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // item latch
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            x_reg    <= s_tdata[3:0];
            y_reg    <= s_tdata[7:4];
            z_reg    <= s_tdata[11:8];
            kind_reg <= s_tdata[15:12];
            oair_reg <= s_tdata[21:16];
        end
    end

    // read tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
            rd_sel_reg <= vfc_pkg::SEL_CENTER;
        end
        else
        begin
            rd_vld_reg <= cmd.rd_en;
            rd_sel_reg <= cmd.rd_sel;
        end
    end

    assign cap_face = rd_sel_reg - 3'd1;

    // capture center kind and neighbor air flags
    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            if (rd_sel_reg == vfc_pkg::SEL_CENTER)
            begin
                center_reg <= rd_data_reg;
            end
            else
            begin
                mask_reg[cap_face] <= nb_in[cap_face] ? (rd_data_reg == vfc_pkg::KIND_AIR)
                                                      : oair_reg[cap_face];
            end
        end
    end

    // face and vertex walk
    assign later_mask = mask_reg & faces_after(face_reg);
    assign last_vtx   = (vtx_reg == vfc_pkg::VTX_LAST) && (later_mask == 6'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            face_reg <= vfc_pkg::FACE_POS_X;
            vtx_reg  <= 3'd0;
        end
        else if (cmd.emit_init)
        begin
            face_reg <= pick_face(mask_reg);
            vtx_reg  <= 3'd0;
        end
        else if (cmd.emit_load)
        begin
            if (vtx_reg == vfc_pkg::VTX_LAST)
            begin
                vtx_reg  <= 3'd0;
                face_reg <= pick_face(later_mask);
            end
            else
            begin
                vtx_reg <= vtx_reg + 3'd1;
            end
        end
    end

    assign tab_entry = vfc_pkg::FACE_TAB[face_reg][vtx_reg];

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            out_last_reg <= last_vtx;
            out_data_reg <= {2'b00,
                             face_reg,
                             vfc_pkg::tex_for(center_reg, face_reg),
                             tab_entry[0],
                             tab_entry[1],
                             cz + {4'd0, tab_entry[2]},
                             cy + {4'd0, tab_entry[3]},
                             cx + {4'd0, tab_entry[4]}};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = out_data_reg;

    // status to the controller
    assign stat.in_mesh  = s_tuser;
    assign stat.skip     = !center_in || (center_reg == vfc_pkg::KIND_AIR) || (mask_reg == 6'd0);
    assign stat.out_free = !out_valid_reg || m_tready;
    assign stat.last_vtx = last_vtx;

    // emission only walks faces whose neighbor is air
    a_face_air: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_load |-> mask_reg[face_reg])
        else $error("emitting a vertex of a covered face");

    // a stalled vertex is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !cmd.emit_load)
        else $error("output register loaded while stalled");

    // store is never written and read in one cycle
    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.store_wr && cmd.rd_en))
        else $error("store written and read together");

    // each face walk starts at its first vertex
    a_init_vtx: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_init |=> (vtx_reg == 3'd0))
        else $error("face walk did not restart at vertex zero");

endmodule

`default_nettype wire

[tb/testbench.sv]
// self-checking testbench for the culled-face voxel mesher
module testbench;
    import vfc_pkg::*;

    localparam logic              CMD_WRITE    = 1'b0;
    localparam logic              CMD_MESH     = 1'b1;
    localparam logic [3:0]        KIND_DIRT    = 4'd2;
    localparam logic signed [7:0] NO_TYPED     = -8'sd1;
    localparam int                BATCH_ITEMS  = 160;
    localparam int                RUN_LIMIT    = 500000;
    localparam int                HOLD_CYCLES  = 400;
    localparam int                DRAIN_CYCLES = 60;
    localparam int                MAX_PRINTED  = 40;

    // one input item plus an optional hand-typed vertex count
    typedef struct packed {
        logic              cmd;
        logic [3:0]        cx;
        logic [3:0]        cy;
        logic [3:0]        cz;
        logic [3:0]        kind;
        logic [5:0]        oair;
        logic signed [7:0] typed_cnt;
    } cell_op_t;

    // one vertex as it leaves the block
    typedef struct packed {
        logic [4:0] vx;
        logic [4:0] vy;
        logic [4:0] vz;
        logic       tu;
        logic       tv;
        logic [1:0] tex;
        logic [2:0] face;
        logic       last;
    } vertex_t;

    // per face and vertex: {dx, dy, dz, u, v}
    localparam logic [4:0] CORNER_UV [6][6] = '{
        '{5'b10000, 5'b11001, 5'b11111, 5'b11111, 5'b10110, 5'b10000},
        '{5'b00100, 5'b01101, 5'b01011, 5'b01011, 5'b00010, 5'b00100},
        '{5'b01100, 5'b11110, 5'b11011, 5'b11011, 5'b01001, 5'b01100},
        '{5'b00001, 5'b10011, 5'b10110, 5'b10110, 5'b00100, 5'b00001},
        '{5'b00100, 5'b10110, 5'b11111, 5'b11111, 5'b01101, 5'b00100},
        '{5'b10010, 5'b00000, 5'b01001, 5'b01001, 5'b11011, 5'b10010}
    };

    // directed items: corners, both boundary cases, every kind and face
    cell_op_t directed_ops [24] = '{
        '{CMD_WRITE, 4'd1,  4'd0,  4'd0,  KIND_AIR,   6'h00, NO_TYPED},
        '{CMD_WRITE, 4'd0,  4'd1,  4'd0,  KIND_AIR,   6'h3F, NO_TYPED},
        '{CMD_WRITE, 4'd0,  4'd0,  4'd1,  KIND_AIR,   6'h15, NO_TYPED},
        '{CMD_WRITE, 4'd0,  4'd0,  4'd0,  KIND_GRASS, 6'h2A, NO_TYPED},
        '{CMD_MESH,  4'd0,  4'd0,  4'd0,  4'hF,       6'h3F, 8'sd36},
        '{CMD_MESH,  4'd0,  4'd0,  4'd0,  KIND_AIR,   6'h00, 8'sd18},
        '{CMD_WRITE, 4'd14, 4'd15, 4'd15, KIND_STONE, 6'h00, NO_TYPED},
        '{CMD_WRITE, 4'd15, 4'd14, 4'd15, KIND_STONE, 6'h3F, NO_TYPED},
        '{CMD_WRITE, 4'd15, 4'd15, 4'd14, KIND_STONE, 6'h0C, NO_TYPED},
        '{CMD_WRITE, 4'd15, 4'd15, 4'd15, 4'hF,       6'h33, NO_TYPED},
        '{CMD_MESH,  4'd15, 4'd15, 4'd15, KIND_STONE, 6'h00, 8'sd0},
        '{CMD_MESH,  4'd15, 4'd15, 4'd15, KIND_AIR,   6'h3F, 8'sd18},
        '{CMD_WRITE, 4'd15, 4'd15, 4'd15, KIND_AIR,   6'h00, NO_TYPED},
        '{CMD_MESH,  4'd15, 4'd15, 4'd15, 4'hF,       6'h3F, 8'sd0},
        '{CMD_WRITE, 4'd8,  4'd8,  4'd9,  KIND_AIR,   6'h01, NO_TYPED},
        '{CMD_WRITE, 4'd6,  4'd8,  4'd9,  KIND_DIRT,  6'h02, NO_TYPED},
        '{CMD_WRITE, 4'd7,  4'd9,  4'd9,  KIND_AIR,   6'h04, NO_TYPED},
        '{CMD_WRITE, 4'd7,  4'd7,  4'd9,  KIND_GRASS, 6'h08, NO_TYPED},
        '{CMD_WRITE, 4'd7,  4'd8,  4'd10, 4'd9,       6'h10, NO_TYPED},
        '{CMD_WRITE, 4'd7,  4'd8,  4'd8,  KIND_AIR,   6'h20, NO_TYPED},
        '{CMD_WRITE, 4'd7,  4'd8,  4'd9,  KIND_STONE, 6'h00, NO_TYPED},
        '{CMD_MESH,  4'd7,  4'd8,  4'd9,  4'd5,       6'h3F, NO_TYPED},
        '{CMD_WRITE, 4'd7,  4'd8,  4'd9,  KIND_DIRT,  6'h00, NO_TYPED},
        '{CMD_MESH,  4'd7,  4'd8,  4'd9,  4'd10,      6'h00, NO_TYPED}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    // shadow of the block store and which cells have been written
    logic [3:0] chunk_kind    [STORE_CELLS];
    bit         chunk_written [STORE_CELLS];

    vertex_t vertices_due [$];
    int      mismatches    = 0;
    int      vertices_seen = 0;
    int      items_sent    = 0;
    int      burst_left    = 0;
    int      cycles        = 0;
    bit      hold_pending  = 0;

    voxel_face_cull_mesher u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // clock and reset
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= RUN_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic bit in_chunk(input int x, input int y, input int z);
        return x >= 0 && x < CHUNK_DIM_X && y >= 0 && y < CHUNK_DIM_Y &&
               z >= 0 && z < CHUNK_DIM_Z;
    endfunction

    function automatic int cell_slot(input int x, input int y, input int z);
        return (x * CHUNK_DIM_Y + y) * CHUNK_DIM_Z + z;
    endfunction

    // neighbor coordinate across one face
    task automatic step_across(input int x, input int y, input int z, input int d,
                               output int nx, output int ny, output int nz);
        nx = x;
        ny = y;
        nz = z;
        case (3'(d))
            FACE_POS_X: nx = x + 1;
            FACE_NEG_X: nx = x - 1;
            FACE_POS_Y: ny = y + 1;
            FACE_NEG_Y: ny = y - 1;
            FACE_POS_Z: nz = z + 1;
            default:    nz = z - 1;
        endcase
    endtask

    function automatic logic [1:0] texture_of(input logic [3:0] kind, input int d);
        logic [1:0] t;
        t = TEX_DIRT;
        if (kind == KIND_GRASS)
        begin
            if (3'(d) == FACE_POS_Y)
                t = TEX_GRASS_TOP;
            else if (3'(d) != FACE_NEG_Y)
                t = TEX_GRASS_SIDE;
        end
        else if (kind == KIND_STONE)
        begin
            t = TEX_STONE;
        end
        return t;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("vertex %0d: %s is %0d, expected %0d", vertices_seen, what, got, want);
    endtask

    // update the shadow store or queue the vertices one accepted item produces
    task automatic apply_item(input cell_op_t op);
        int         x;
        int         y;
        int         z;
        int         nx;
        int         ny;
        int         nz;
        int         n;
        int         total;
        logic [3:0] cur;
        logic [5:0] open_faces;
        logic [4:0] c;
        vertex_t    vtx;
        x = op.cx;
        y = op.cy;
        z = op.cz;
        n = 0;
        if (in_chunk(x, y, z))
        begin
            if (op.cmd == CMD_WRITE)
            begin
                chunk_kind[cell_slot(x, y, z)]    = op.kind;
                chunk_written[cell_slot(x, y, z)] = 1'b1;
            end
            else
            begin
                cur        = chunk_kind[cell_slot(x, y, z)];
                open_faces = '0;
                // a neighbor outside the chunk takes its air flag from the item
                for (int d = 0; d < NUM_FACES; d++)
                begin
                    step_across(x, y, z, d, nx, ny, nz);
                    if (in_chunk(nx, ny, nz))
                        open_faces[d] = chunk_kind[cell_slot(nx, ny, nz)] == KIND_AIR;
                    else
                        open_faces[d] = op.oair[d];
                end
                if (cur == KIND_AIR)
                    open_faces = '0;
                total = $countones(open_faces) * 6;
                for (int d = 0; d < NUM_FACES; d++)
                begin
                    if (open_faces[d])
                    begin
                        for (int v = 0; v < 6; v++)
                        begin
                            c        = CORNER_UV[d][v];
                            vtx.vx   = 5'(x) + 5'(c[4]);
                            vtx.vy   = 5'(y) + 5'(c[3]);
                            vtx.vz   = 5'(z) + 5'(c[2]);
                            vtx.tu   = c[1];
                            vtx.tv   = c[0];
                            vtx.tex  = texture_of(cur, d);
                            vtx.face = 3'(d);
                            vtx.last = (n == total - 1);
                            vertices_due = {vertices_due, vtx};
                            n++;
                        end
                    end
                end
            end
        end
        if (op.typed_cnt != NO_TYPED && n != op.typed_cnt)
            report_mismatch("vertex count of a directed item", n, op.typed_cnt);
    endtask

    // present one item in bursts with random gaps, then wait for acceptance
    task automatic send_item(input cell_op_t op);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 10);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        // cell_x, cell_y, cell_z, block_kind, outside_air from the lowest bit up
        s_tdata  <= {2'b00, op.oair, op.kind, op.cz, op.cy, op.cx};
        s_tuser  <= op.cmd;
        do @(posedge clk); while (!s_tready);
        apply_item(op);
        items_sent++;
        burst_left--;
    endtask

    function automatic cell_op_t make_op(input logic cmd, input int x, input int y,
                                         input int z, input logic [3:0] kind);
        cell_op_t op;
        op.cmd       = cmd;
        op.cx        = 4'(x);
        op.cy        = 4'(y);
        op.cz        = 4'(z);
        op.kind      = kind;
        op.oair      = 6'($urandom_range(0, 63));
        op.typed_cnt = NO_TYPED;
        return op;
    endfunction

    // true when the cell and every neighbor inside the chunk hold a written type
    function automatic bit cell_ready(input int x, input int y, input int z);
        int nx;
        int ny;
        int nz;
        bit ok;
        ok = chunk_written[cell_slot(x, y, z)];
        for (int d = 0; d < NUM_FACES; d++)
        begin
            nx = x + ((d == 0) ? 1 : (d == 1) ? -1 : 0);
            ny = y + ((d == 2) ? 1 : (d == 3) ? -1 : 0);
            nz = z + ((d == 4) ? 1 : (d == 5) ? -1 : 0);
            if (in_chunk(nx, ny, nz) && !chunk_written[cell_slot(nx, ny, nz)])
                ok = 1'b0;
        end
        return ok;
    endfunction

    // boundary coordinates come up often
    function automatic int pick_axis();
        int r;
        r = $urandom_range(0, 3);
        return (r == 0) ? 0 : (r == 1) ? 15 : $urandom_range(0, 15);
    endfunction

    function automatic logic [3:0] pick_kind(input bit solid);
        int r;
        r = $urandom_range(solid ? 4 : 0, 9);
        case (r)
            0, 1, 2, 3: return KIND_AIR;
            4:          return KIND_GRASS;
            5:          return KIND_DIRT;
            6:          return KIND_STONE;
            default:    return 4'($urandom_range(1, 15));
        endcase
    endfunction

    // one random round: mostly fill a neighborhood then mesh its center
    task automatic mesh_round();
        int x;
        int y;
        int z;
        int nx;
        int ny;
        int nz;
        x = pick_axis();
        y = pick_axis();
        z = pick_axis();
        if ($urandom_range(0, 4) == 0)
        begin
            // noise: a lone write, or a mesh of an already safe cell
            if ($urandom_range(0, 1) == 1 && cell_ready(x, y, z))
                send_item(make_op(CMD_MESH, x, y, z, 4'($urandom_range(0, 15))));
            else
                send_item(make_op(CMD_WRITE, x, y, z, 4'($urandom_range(0, 15))));
        end
        else
        begin
            for (int d = 0; d < NUM_FACES; d++)
            begin
                step_across(x, y, z, d, nx, ny, nz);
                if (in_chunk(nx, ny, nz) &&
                    (!chunk_written[cell_slot(nx, ny, nz)] || $urandom_range(0, 2) == 0))
                    send_item(make_op(CMD_WRITE, nx, ny, nz, pick_kind(1'b0)));
            end
            if (!chunk_written[cell_slot(x, y, z)] || $urandom_range(0, 2) != 0)
                send_item(make_op(CMD_WRITE, x, y, z,
                                  ($urandom_range(0, 7) == 0) ? KIND_AIR : pick_kind(1'b1)));
            send_item(make_op(CMD_MESH, x, y, z, 4'($urandom_range(0, 15))));
        end
    endtask

    // stimulus and end of run
    initial
    begin
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_WRITE;
        @(posedge rst_n);
        foreach (directed_ops[i])
            send_item(directed_ops[i]);
        hold_pending = 1'b1;
        while (items_sent < BATCH_ITEMS)
            mesh_round();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (vertices_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && vertices_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // output side: a changing random stall pattern and one long hold-off
    initial
    begin : vertex_sink
        int          mode;
        logic [15:0] pat;
        m_tready = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 2);
            pat  = 16'($urandom);
            if (pat == '0)
                pat = 16'h8001;
            for (int n = 0; n < 64; n++)
            begin
                @(negedge clk);
                if (hold_pending)
                begin
                    hold_pending = 1'b0;
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES - 1) @(negedge clk);
                end
                else
                begin
                    case (mode)
                        0:
                        begin
                            m_tready <= 1'b1;
                        end
                        1:
                        begin
                            m_tready <= pat[0];
                            pat = {pat[0], pat[15:1]};
                        end
                        default:
                        begin
                            m_tready <= ($urandom_range(0, 3) != 0);
                        end
                    endcase
                end
            end
        end
    end

    // compare each accepted vertex with the oldest one due
    always @(posedge clk)
    begin : vertex_check
        vertex_t got;
        vertex_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.vx   = m_tdata[4:0];
            got.vy   = m_tdata[9:5];
            got.vz   = m_tdata[14:10];
            got.tu   = m_tdata[15];
            got.tv   = m_tdata[16];
            got.tex  = m_tdata[18:17];
            got.face = m_tdata[21:19];
            got.last = m_tlast;
            if (vertices_due.size() == 0)
            begin
                report_mismatch("unexpected vertex, face_dir", got.face, -1);
            end
            else
            begin
                want = vertices_due.pop_front();
                if (got.vx != want.vx)
                    report_mismatch("vert_x", got.vx, want.vx);
                if (got.vy != want.vy)
                    report_mismatch("vert_y", got.vy, want.vy);
                if (got.vz != want.vz)
                    report_mismatch("vert_z", got.vz, want.vz);
                if (got.tu != want.tu)
                    report_mismatch("tex_u", got.tu, want.tu);
                if (got.tv != want.tv)
                    report_mismatch("tex_v", got.tv, want.tv);
                if (got.tex != want.tex)
                    report_mismatch("texture_sel", got.tex, want.tex);
                if (got.face != want.face)
                    report_mismatch("face_dir", got.face, want.face);
                if (got.last != want.last)
                    report_mismatch("last", got.last, want.last);
            end
            vertices_seen++;
        end
    end

endmodule
